FILE: src/lmtq_pkg.sv
// Package for the line message transmit queue framer.
// Holds the input and output word types, command codes and the sequencer state type.
// No dependencies.
package lmtq_pkg;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_SEND   = 2'd1;
	localparam logic [1:0] CMD_DONE   = 2'd2;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
		logic       first_of_message;
		logic [7:0] message_length;
		logic       force_req;
	} lmtq_in_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       byte_valid;
		logic       last_of_run;
		logic [5:0] sent_length;
		logic [5:0] queue_fill;
	} lmtq_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LEN,
		ST_PAYLOAD,
		ST_STATUS
	} lmtq_state_t;

endpackage

FILE: src/lmtq_cell.sv
// One byte cell of the queue shift chain.
// Depends on lmtq_pkg for the newline code.
module lmtq_cell
	import lmtq_pkg::*;
(
	input  logic       clk,
	input  logic       wr_en,
	input  logic [7:0] wr_data,
	input  logic       shift,
	input  logic [7:0] next_data,
	output logic [7:0] data,
	output logic       is_nl
);

	logic [7:0] data_q;

	// Write wins; otherwise take the neighbour's byte on a shift.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_q <= wr_data;
		end else if (shift) begin
			data_q <= next_data;
		end
	end

	assign data  = data_q;
	assign is_nl = (data_q == NEWLINE_CHAR);

endmodule

FILE: src/line_message_tx_queue_framer.sv
// Top level of the line message transmit queue framer.
// Depends on lmtq_pkg and lmtq_cell.
//
//  Channel | Signals                        | Word
//  --------+--------------------------------+-------------------------------------
//  cmd     | cmd_valid, cmd_ready, cmd      | append byte, send request, tx done
//  pkt     | pkt_valid, pkt_ready, pkt      | length byte, payload bytes or status
//
// Sequence: a send runs the newline scan (one cell per cycle, skipped on a forced
// or busy send), then presents the output words: the length byte and len payload
// bytes, or a single status word. The command side is held off for the whole send.
// Reset needs no clearing pass: only cells below the fill count are ever read. A
// stall on the packet side holds the sequencer in its output states.
module line_message_tx_queue_framer
	import lmtq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  lmtq_in_t  cmd,
	output logic      pkt_valid,
	input  logic      pkt_ready,
	output lmtq_out_t pkt
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = $clog2(QUEUE_DEPTH);

	lmtq_state_t state_q, state_d;

	logic [CW-1:0] fill_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] scan_q;
	logic          busy_q;
	logic          drop_q;
	logic          out_valid_q;
	lmtq_out_t     out_q;

	logic [7:0]             cell_data [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] nl_vec;
	logic [QUEUE_DEPTH-1:0] cell_wr;

	logic          cmd_fire;
	logic [8:0]    need_sum;
	logic          fits;
	logic          store;
	logic          scan_end;
	logic          scan_hit;
	logic [CW-1:0] found_len;
	logic          emit;
	logic          load;
	logic          shift;
	lmtq_out_t     word;

	assign cmd_fire  = cmd_valid && cmd_ready;
	assign cmd_ready = (state_q == ST_IDLE);

	// Admit a new message only when its whole declared length fits.
	assign need_sum = 9'(fill_q) + 9'(cmd.message_length);
	assign fits     = (cmd.message_length != 8'd0) && (need_sum <= 9'(QUEUE_DEPTH));
	assign store    = cmd_fire && (cmd.command == CMD_APPEND)
		&& (cmd.first_of_message ? fits : !drop_q)
		&& (fill_q != CW'(QUEUE_DEPTH));

	// Scan walks one cell per cycle from the front looking for a newline.
	assign scan_end  = (scan_q == fill_q);
	assign scan_hit  = !scan_end && nl_vec[scan_q[IW-1:0]];
	assign found_len = scan_q + 1'b1;

	// Cell chain: cell i takes cell i+1 on a shift, the tail takes zero.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [7:0] next_byte;

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_byte = 8'h00;
		end else begin : g_mid
			assign next_byte = cell_data[i+1];
		end

		assign cell_wr[i] = store && (fill_q == CW'(i));

		lmtq_cell u_cell (
			.clk       (clk),
			.wr_en     (cell_wr[i]),
			.wr_data   (cmd.data_byte),
			.shift     (shift),
			.next_data (next_byte),
			.data      (cell_data[i]),
			.is_nl     (nl_vec[i])
		);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire && (cmd.command == CMD_SEND)) begin
					if (busy_q) begin
						state_d = ST_STATUS;
					end else if (cmd.force_req) begin
						state_d = ST_LEN;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_STATUS;
				end else if (scan_hit) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (load) begin
					state_d = (len_q == '0) ? ST_IDLE : ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				if (load && (rem_q == CW'(1))) begin
					state_d = ST_IDLE;
				end
			end
			ST_STATUS: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: which word to present and when to advance.
	always_comb begin
		emit = 1'b0;
		word = '0;
		case (state_q)
			ST_LEN: begin
				emit             = 1'b1;
				word.packet_byte = 8'(len_q);
				word.byte_valid  = 1'b1;
				word.last_of_run = (len_q == '0);
				word.sent_length = 6'(len_q);
				word.queue_fill  = 6'(fill_q);
			end
			ST_PAYLOAD: begin
				emit             = 1'b1;
				word.packet_byte = cell_data[0];
				word.byte_valid  = 1'b1;
				word.last_of_run = (rem_q == CW'(1));
				word.sent_length = 6'(len_q);
				word.queue_fill  = 6'(fill_q);
			end
			ST_STATUS: begin
				emit             = 1'b1;
				word.last_of_run = 1'b1;
				word.queue_fill  = 6'(fill_q);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign load  = emit && (!out_valid_q || pkt_ready);
	assign shift = load && (state_q == ST_PAYLOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			scan_q  <= '0;
			busy_q  <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (store) begin
				fill_q <= fill_q + 1'b1;
			end

			// Remember whether the rest of this message is to be dropped.
			if (cmd_fire && (cmd.command == CMD_APPEND) && cmd.first_of_message) begin
				drop_q <= !fits;
			end

			if (cmd_fire && (cmd.command == CMD_DONE)) begin
				busy_q <= 1'b0;
			end

			if (state_q == ST_IDLE && cmd_fire && (cmd.command == CMD_SEND) && !busy_q) begin
				if (cmd.force_req) begin
					len_q  <= fill_q;
					rem_q  <= fill_q;
					fill_q <= '0;
					busy_q <= 1'b1;
				end else begin
					scan_q <= '0;
				end
			end

			if (state_q == ST_SCAN) begin
				if (scan_hit) begin
					len_q  <= found_len;
					rem_q  <= found_len;
					fill_q <= fill_q - found_len;
					busy_q <= 1'b1;
				end else if (!scan_end) begin
					scan_q <= found_len;
				end
			end

			if (shift) begin
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	// Output register: hold the word until taken, refill in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pkt_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= word;
		end
	end

	assign pkt_valid = out_valid_q;
	assign pkt       = out_q;

endmodule
